// ===== rtl/core/bblur_pkg.sv =====
// ----------------------------------------------------------------------------
// bblur_pkg: shared types and constants of the 3x3 box blur
// Beat payloads, register indexes, control tag and divider constants.
// ----------------------------------------------------------------------------
`default_nettype none

package bblur_pkg;

	localparam int PIX_W          = 8;
	localparam int FRAME_WIDTH_W  = 11;
	localparam int FRAME_HEIGHT_W = 13;
	localparam int CFG_DATA_W     = 13;
	localparam int CFG_IDX_W      = 1;
	localparam int IN_ROW_W       = 13;
	localparam int OUT_ROW_W      = 12;
	localparam int HEIGHT_MAX     = 4096;
	localparam int WIDTH_RESET    = 640;
	localparam int HEIGHT_RESET   = 480;

	// window sum of nine pixels and the reciprocal multiply that divides it
	localparam int SUM_W       = PIX_W + 4;
	localparam int RECIP_W     = 14;
	localparam int PROD_W      = SUM_W + RECIP_W;
	localparam int RECIP_SHIFT = 15;
	localparam logic [RECIP_W-1:0] RECIP_4 = 14'd8192;
	localparam logic [RECIP_W-1:0] RECIP_6 = 14'd5462;
	localparam logic [RECIP_W-1:0] RECIP_9 = 14'd3641;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef enum logic [1:0] {
		DIV_4,
		DIV_6,
		DIV_9
	} div_sel_t;

	typedef struct packed {
		logic             op;
		logic [PIX_W-1:0] pixel;
	} in_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] blurred;
		logic             end_of_row;
		logic             end_of_frame;
	} out_item_t;

	// per-item control from the position counters to the datapath
	typedef struct packed {
		logic             drain;
		logic [PIX_W-1:0] pixel;
		logic             emit;
		logic             top_ok;
		logic             bot_ok;
		logic             left_ok;
		logic             right_ok;
		logic             end_of_row;
		logic             end_of_frame;
	} tag_t;

endpackage

`default_nettype wire

// ===== rtl/core/bblur_ram.sv =====
// ----------------------------------------------------------------------------
// bblur_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module bblur_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/bblur_ctrl.sv =====
// ----------------------------------------------------------------------------
// bblur_ctrl: frame registers and position counters
// Holds frame size, tracks input and output positions, issues line store reads.
// ----------------------------------------------------------------------------
`default_nettype none

module bblur_ctrl #(
	parameter int MAX_WIDTH = 1024,
	localparam int COL_W = $clog2(MAX_WIDTH)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [bblur_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bblur_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  bblur_pkg::in_item_t                  in_data,
	output logic                                 item_load,
	output bblur_pkg::tag_t                      item_tag,
	output logic [COL_W-1:0]                     item_col
);

	import bblur_pkg::*;

	localparam int WID_W = $clog2(MAX_WIDTH + 1);
	localparam int CNT_W = COL_W + 1;
	localparam int WidthReset = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

	logic [WID_W-1:0]          w_q;
	logic [FRAME_HEIGHT_W-1:0] h_q;
	logic [COL_W-1:0]          in_col_q;
	logic [IN_ROW_W-1:0]       in_row_q;
	logic [COL_W-1:0]          out_col_q;
	logic [OUT_ROW_W-1:0]      out_row_q;

	logic [WID_W-1:0]          w_next;
	logic [FRAME_HEIGHT_W-1:0] h_next;
	logic                      pending;
	logic                      is_drain;
	logic                      effective;
	logic                      ready_out;
	logic                      in_col_last;
	logic                      out_col_last;
	logic                      out_row_last;
	logic                      step;
	logic                      emit;

	// clamp written sizes into the supported range
	always_comb begin
		int unsigned wv;
		int unsigned hv;
		wv = 32'(cfg_data[FRAME_WIDTH_W-1:0]);
		hv = 32'(cfg_data[FRAME_HEIGHT_W-1:0]);
		if (wv < 32'd2) begin
			wv = 32'd2;
		end else if (wv > 32'(MAX_WIDTH)) begin
			wv = 32'(MAX_WIDTH);
		end
		if (hv < 32'd2) begin
			hv = 32'd2;
		end else if (hv > 32'(HEIGHT_MAX)) begin
			hv = 32'(HEIGHT_MAX);
		end
		w_next = WID_W'(wv);
		h_next = FRAME_HEIGHT_W'(hv);
	end

	assign pending      = in_row_q < IN_ROW_W'(h_q);
	assign is_drain     = in_data.op == OP_DRAIN;
	assign effective    = is_drain ? !pending : pending;
	assign step         = in_valid && !in_stall && effective;
	assign ready_out    = (in_row_q >= IN_ROW_W'(2))
		|| (in_row_q == IN_ROW_W'(1) && in_col_q != '0);
	assign emit         = step && ready_out;
	assign in_col_last  = (CNT_W'(in_col_q) + CNT_W'(1)) >= CNT_W'(w_q);
	assign out_col_last = (CNT_W'(out_col_q) + CNT_W'(1)) >= CNT_W'(w_q);
	assign out_row_last = (IN_ROW_W'(out_row_q) + IN_ROW_W'(1)) >= IN_ROW_W'(h_q);

	always_comb begin
		item_tag.drain        = is_drain;
		item_tag.pixel        = in_data.pixel;
		item_tag.emit         = ready_out;
		item_tag.top_ok       = out_row_q != '0;
		item_tag.bot_ok       = !out_row_last;
		item_tag.left_ok      = out_col_q != '0;
		item_tag.right_ok     = !out_col_last;
		item_tag.end_of_row   = out_col_last;
		item_tag.end_of_frame = out_col_last && out_row_last;
	end

	assign item_load = step;
	assign item_col  = in_col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q       <= WID_W'(WidthReset);
			h_q       <= FRAME_HEIGHT_W'(HEIGHT_RESET);
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  w_q <= w_next;
				REG_FRAME_HEIGHT: h_q <= h_next;
			endcase
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (step) begin
			if (emit && out_col_last && out_row_last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (in_col_last) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + IN_ROW_W'(1);
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
				if (emit) begin
					if (out_col_last) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + OUT_ROW_W'(1);
					end else begin
						out_col_q <= out_col_q + COL_W'(1);
					end
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_in_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(in_col_q) < CNT_W'(w_q))
		else $error("input column beyond frame width");

	a_out_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		IN_ROW_W'(out_row_q) < IN_ROW_W'(h_q))
		else $error("output row beyond frame height");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		emit && item_tag.end_of_frame |=> in_row_q == '0 && in_col_q == '0)
		else $error("positions not cleared after last output of frame");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/bblur_dp.sv =====
// ----------------------------------------------------------------------------
// bblur_dp: line store write-back, window and mean datapath
// Consumes line store reads, updates the 3x3 window, sums and divides.
// ----------------------------------------------------------------------------
`default_nettype none

module bblur_dp #(
	parameter int COL_W = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_load,
	input  bblur_pkg::tag_t               item_tag,
	input  logic [COL_W-1:0]              item_col,
	input  logic [bblur_pkg::PIX_W-1:0]   older_rd,
	input  logic [bblur_pkg::PIX_W-1:0]   recent_rd,
	output logic                          s1_free,
	output logic                          wr_en,
	output logic [COL_W-1:0]              wr_addr,
	output logic [bblur_pkg::PIX_W-1:0]   older_wd,
	output logic [bblur_pkg::PIX_W-1:0]   recent_wd,
	output logic                          out_valid,
	input  logic                          out_stall,
	output bblur_pkg::out_item_t          out_data
);

	import bblur_pkg::*;

	logic             valid_s1;
	tag_t             tag_s1;
	logic [COL_W-1:0] col_s1;

	logic             valid_s2;
	logic [SUM_W-1:0] sum_s2;
	div_sel_t         div_s2;
	logic             eor_s2;
	logic             eof_s2;

	logic             out_valid_q;
	out_item_t        out_data_q;

	logic [PIX_W-1:0] win_q  [3][3];
	logic [PIX_W-1:0] win_nx [3][3];
	logic [PIX_W-1:0] col_new [3];
	logic [2:0]       row_ok;
	logic [2:0]       col_ok;
	logic [SUM_W-1:0] sum_nx;
	div_sel_t         div_nx;

	logic              out_free;
	logic              s2_free;
	logic              s1_fire;
	logic              s2_fire;
	logic [RECIP_W-1:0] recip;
	logic [PROD_W-1:0]  prod;

	assign out_free = !out_valid_q || !out_stall;
	assign s2_free  = !valid_s2 || out_free;
	assign s2_fire  = valid_s2 && out_free;
	// items that produce no output leave s1 without waiting for s2
	assign s1_fire  = valid_s1 && (!tag_s1.emit || s2_free);
	assign s1_free  = !valid_s1 || s1_fire;

	// write-back lands as s1 leaves; the same column is read again only
	// after the whole row has passed through s1, so no forwarding is needed
	assign wr_en     = s1_fire && !tag_s1.drain;
	assign wr_addr   = col_s1;
	assign older_wd  = recent_rd;
	assign recent_wd = tag_s1.pixel;

	assign col_new[0] = older_rd;
	assign col_new[1] = recent_rd;
	assign col_new[2] = tag_s1.drain ? '0 : tag_s1.pixel;

	assign row_ok = {tag_s1.bot_ok, 1'b1, tag_s1.top_ok};
	assign col_ok = {tag_s1.right_ok, 1'b1, tag_s1.left_ok};

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_nx[r][0] = win_q[r][1];
			win_nx[r][1] = win_q[r][2];
			win_nx[r][2] = col_new[r];
		end
	end

	// masked sum of the shifted window, neighbors outside the frame drop out
	always_comb begin
		sum_nx = '0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (row_ok[r] && col_ok[c]) begin
					sum_nx = sum_nx + SUM_W'(win_nx[r][c]);
				end
			end
		end
	end

	always_comb begin
		priority if (row_ok[0] && row_ok[2] && col_ok[0] && col_ok[2]) begin
			div_nx = DIV_9;
		end else if ((row_ok[0] && row_ok[2]) || (col_ok[0] && col_ok[2])) begin
			div_nx = DIV_6;
		end else begin
			div_nx = DIV_4;
		end
	end

	always_comb begin
		unique case (div_s2)
			DIV_4:   recip = RECIP_4;
			DIV_6:   recip = RECIP_6;
			DIV_9:   recip = RECIP_9;
			default: recip = RECIP_4;
		endcase
	end

	assign prod = PROD_W'(sum_s2) * PROD_W'(recip);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else begin
			if (s1_free) begin
				valid_s1 <= item_load;
			end
			if (s2_free) begin
				valid_s2 <= s1_fire && tag_s1.emit;
			end
			if (out_free) begin
				out_valid_q <= valid_s2;
			end
			if (s1_fire) begin
				win_q <= win_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_load && s1_free) begin
			tag_s1 <= item_tag;
			col_s1 <= item_col;
		end
		if (s1_fire && tag_s1.emit && s2_free) begin
			sum_s2 <= sum_nx;
			div_s2 <= div_nx;
			eor_s2 <= tag_s1.end_of_row;
			eof_s2 <= tag_s1.end_of_frame;
		end
		if (s2_fire) begin
			out_data_q.blurred      <= prod[RECIP_SHIFT +: PIX_W];
			out_data_q.end_of_row   <= eor_s2;
			out_data_q.end_of_frame <= eof_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTHESIS
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		item_load |-> s1_free)
		else $error("item loaded into occupied first stage");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_free |=> valid_s2 && $stable(sum_s2))
		else $error("second stage lost its item while blocked");

	a_eof_eor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !out_data_q.end_of_frame || out_data_q.end_of_row)
		else $error("end of frame without end of row");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/box_blur_3x3_edge_average.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_average: 3x3 mean filter over in-frame neighbors
// Raster-order pixel stream in, blurred raster-order stream out.
// ----------------------------------------------------------------------------
// the beat that completes a window passes through s1, s2 and the output register to its output beat
// throughput: one beat per cycle while the output is not stalled, set by the single read and write
//   port of each line store, at most one access of each per beat
// output lags input by one row plus one pixel; frame_width+1 drain beats flush
// reset: frame 640x480, positions and window cleared; line stores not cleared
`default_nettype none

module box_blur_3x3_edge_average #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bblur_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bblur_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  bblur_pkg::in_item_t              in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output bblur_pkg::out_item_t             out_data
);

	import bblur_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);

	logic             item_load;
	tag_t             item_tag;
	logic [COL_W-1:0] item_col;
	logic             s1_free;
	logic             wr_en;
	logic [COL_W-1:0] wr_addr;
	logic [PIX_W-1:0] older_wd;
	logic [PIX_W-1:0] recent_wd;
	logic [PIX_W-1:0] older_rd;
	logic [PIX_W-1:0] recent_rd;

	assign in_stall = !s1_free;

	bblur_ctrl #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.item_load (item_load),
		.item_tag  (item_tag),
		.item_col  (item_col)
	);

	// row two above the incoming pixel
	bblur_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_older (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (older_wd),
		.re    (item_load),
		.raddr (item_col),
		.rdata (older_rd)
	);

	// row directly above the incoming pixel
	bblur_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_recent (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (recent_wd),
		.re    (item_load),
		.raddr (item_col),
		.rdata (recent_rd)
	);

	bblur_dp #(
		.COL_W (COL_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_load (item_load),
		.item_tag  (item_tag),
		.item_col  (item_col),
		.older_rd  (older_rd),
		.recent_rd (recent_rd),
		.s1_free   (s1_free),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.older_wd  (older_wd),
		.recent_wd (recent_wd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
